// ===== hw/rtl/crcbs_pkg.sv =====
`default_nettype none
package crcbs_pkg;

    localparam int MAX_DEGREE = 32;
    localparam int WIN_W      = MAX_DEGREE;
    localparam int DEG_W      = 6;
    localparam int CFG_W      = 32;
    localparam int IDX_W      = 2;
    localparam int PTR_W      = $clog2(MAX_DEGREE);

    localparam logic [IDX_W-1:0] REG_POLY_LOW_TERMS = 2'd0;
    localparam logic [IDX_W-1:0] REG_POLY_DEGREE    = 2'd1;
    localparam logic [IDX_W-1:0] REG_CHECK_MODE     = 2'd2;

    localparam logic [1:0] KIND_QUOT = 2'd0;
    localparam logic [1:0] KIND_REM  = 2'd1;
    localparam logic [1:0] KIND_VERD = 2'd2;

    localparam logic [WIN_W-1:0] POLY_RESET = 32'd3;
    localparam logic [DEG_W-1:0] DEG_RESET  = 6'd4;

    typedef struct packed {
        logic             check;
        logic             bit_val;
        logic             last;
        logic [DEG_W-1:0] deg;
        logic [WIN_W-1:0] rem;
    } t_job;

endpackage
`default_nettype wire

// ===== hw/rtl/crcbs_front.sv =====
`default_nettype none
module crcbs_front
    import crcbs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             i_in_valid,
    input  wire logic             i_data_bit,
    input  wire logic             i_last_bit,
    input  wire logic             i_full,
    output logic                  o_push,
    output t_job                  o_job
);

    logic [WIN_W-1:0] r_poly;
    logic [DEG_W-1:0] r_deg;
    logic             r_check;
    logic [WIN_W-1:0] r_win;
    logic [WIN_W-1:0] n_win;

    logic [DEG_W-1:0] eff_deg;
    logic [WIN_W-1:0] mask;
    logic [WIN_W-1:0] w;
    logic [WIN_W-1:0] poly;
    logic [WIN_W-1:0] upd;
    logic             top;
    logic             fb;
    logic             accept;

    always_comb begin
        if (r_deg == '0) begin
            eff_deg = DEG_W'(1);
        end else if (r_deg > DEG_W'(MAX_DEGREE)) begin
            eff_deg = DEG_W'(MAX_DEGREE);
        end else begin
            eff_deg = r_deg;
        end
        for (int k = 0; k < WIN_W; k++) begin
            mask[k] = (DEG_W'(k) < eff_deg);
        end
    end

    assign w      = r_win & mask;
    assign poly   = r_poly & mask;
    assign top    = w[PTR_W'(eff_deg - DEG_W'(1))];
    assign fb     = i_data_bit ^ top;
    assign accept = i_in_valid && !i_full;

    always_comb begin
        if (!r_check) begin
            upd = ((w << 1) & mask) ^ (fb ? poly : '0);
        end else begin
            upd = ((w << 1) | WIN_W'(i_data_bit)) & mask;
            upd = upd ^ (top ? poly : '0);
        end
        n_win = i_last_bit ? '0 : upd;
    end

    assign o_push        = accept && (!r_check || i_last_bit);
    assign o_job.check   = r_check;
    assign o_job.bit_val = r_check ? (upd != '0) : fb;
    assign o_job.last    = i_last_bit;
    assign o_job.deg     = eff_deg;
    assign o_job.rem     = upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly  <= POLY_RESET;
            r_deg   <= DEG_RESET;
            r_check <= 1'b0;
            r_win   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_POLY_LOW_TERMS: r_poly  <= i_cfg_data;
                    REG_POLY_DEGREE:    r_deg   <= i_cfg_data[DEG_W-1:0];
                    REG_CHECK_MODE:     r_check <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_win <= n_win;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/crcbs_queue.sv =====
`default_nettype none
module crcbs_queue
    import crcbs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    input  wire logic i_pop,
    output logic      o_valid,
    output logic      o_full,
    output t_job      o_job
);

    t_job       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/crcbs_back.sv =====
`default_nettype none
module crcbs_back
    import crcbs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  t_job      i_q_job,
    output logic      o_pop,
    input  wire logic i_out_stall,
    output logic      o_out_valid,
    output logic      o_out_bit,
    output logic [1:0] o_result_kind,
    output logic      o_run_end
);

    logic             r_active;
    logic [DEG_W-1:0] r_cnt;
    logic [WIN_W-1:0] r_rem;
    logic             r_ovalid;
    logic             r_obit;
    logic [1:0]       r_okind;
    logic             r_oend;
    logic             take;
    logic [DEG_W-1:0] cnt_m1;

    assign take   = !r_ovalid || !i_out_stall;
    assign o_pop  = take && !r_active && i_q_valid;
    assign cnt_m1 = r_cnt - DEG_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_ovalid <= 1'b0;
        end else if (take) begin
            if (r_active) begin
                r_ovalid <= 1'b1;
                if (r_cnt == DEG_W'(1)) begin
                    r_active <= 1'b0;
                end
            end else if (i_q_valid) begin
                r_ovalid <= 1'b1;
                r_active <= !i_q_job.check && i_q_job.last;
            end else begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (r_active) begin
                r_obit  <= r_rem[cnt_m1[PTR_W-1:0]];
                r_okind <= KIND_REM;
                r_oend  <= (r_cnt == DEG_W'(1));
                r_cnt   <= cnt_m1;
            end else if (i_q_valid) begin
                r_obit <= i_q_job.bit_val;
                r_rem  <= i_q_job.rem;
                r_cnt  <= i_q_job.deg;
                if (i_q_job.check) begin
                    r_okind <= KIND_VERD;
                    r_oend  <= 1'b1;
                end else begin
                    r_okind <= KIND_QUOT;
                    r_oend  <= 1'b0;
                end
            end
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_out_bit     = r_obit;
    assign o_result_kind = r_okind;
    assign o_run_end     = r_oend;

endmodule
`default_nettype wire

// ===== hw/rtl/crc_bit_serial_generate_check.sv =====
`default_nettype none
// Bit-serial CRC generate/check. One input bit is accepted per cycle while
// o_in_stall is low. In generate mode each bit yields a quotient bit; the
// last bit of a message is followed by D remainder bits (MSB first, D =
// poly_degree clamped to 1..32). In check mode only the last bit yields a
// result, the error flag. Input stalls only when the two-entry queue between
// the division stage and the output sequencer is full, i.e. while remainder
// bits are streaming out or the output is stalled. Configure only while idle.
module crc_bit_serial_generate_check
    import crcbs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic             i_data_bit,
    input  wire logic             i_last_bit,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic                  o_out_bit,
    output logic [1:0]            o_result_kind,
    output logic                  o_run_end
);

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_q_valid;
    t_job w_job_in;
    t_job w_job_out;

    assign o_in_stall = w_full;

    crcbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_data_bit  (i_data_bit),
        .i_last_bit  (i_last_bit),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_job       (w_job_in)
    );

    crcbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_full),
        .o_job   (w_job_out)
    );

    crcbs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_job       (w_job_out),
        .o_pop         (w_pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_bit     (o_out_bit),
        .o_result_kind (o_result_kind),
        .o_run_end     (o_run_end)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("push into full queue");

    a_quot_not_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == KIND_QUOT) |-> !o_run_end)
        else $error("quotient bit flagged as run end");

    a_verd_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == KIND_VERD) |-> o_run_end)
        else $error("verdict without run end");

endmodule
`default_nettype wire
